[rtl/psbc_pkg.sv]
`default_nettype none
package psbc_pkg;

   localparam int MaxElementsDefault = 1024;
   localparam int ValueWidthDefault  = 20;
   localparam int ElementPortWidth   = 20;
   localparam int BudgetWidth        = 32;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_READY = 2'd1,
      ST_TRUNCATED = 2'd2
   } status_type;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_INS_RD  = 9'b000000010,
      S_INS_CMP = 9'b000000100,
      S_PFX_RD  = 9'b000001000,
      S_PFX_ACC = 9'b000010000,
      S_Q_RD    = 9'b000100000,
      S_Q_CMP   = 9'b001000000,
      S_RESP    = 9'b010000000,
      S_SPARE   = 9'b100000000
   } state_type;

endpackage
`default_nettype wire

[rtl/psbc_ram.sv]
`default_nettype none
module psbc_ram import psbc_pkg::*; #(
   parameter int Width = ValueWidthDefault,
   parameter int Depth = MaxElementsDefault
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/prefix_sum_budget_count.sv]
`default_nettype none
// Load: the insertion reads each stored element above the new value and shifts it up one place.
// Set completion: a read and an accumulate step per kept element form the prefix sums.
// Query: a registered read and a compare per binary-search step over the prefix store (11 steps at
// 1024 entries), then a response state that waits until the output register is free.
// One item is in flight at a time. Synchronous reset clears the count and
// flags; store contents are left as they are.
module prefix_sum_budget_count import psbc_pkg::*; #(
   parameter int MAX_ELEMENTS = MaxElementsDefault,
   parameter int VALUE_WIDTH  = ValueWidthDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_command,
   input  wire logic [ElementPortWidth-1:0]         req_element_value,
   input  wire logic                                req_last_element,
   input  wire logic [BudgetWidth-1:0]              req_query_sum,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [$clog2(MAX_ELEMENTS+1)-1:0]        rsp_fit_count,
   output logic [1:0]                               rsp_status
);

   localparam int AW  = $clog2(MAX_ELEMENTS);
   localparam int CW  = $clog2(MAX_ELEMENTS + 1);
   localparam int PW  = VALUE_WIDTH + AW;
   localparam int CPW = (PW > BudgetWidth) ? PW : BudgetWidth;
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ELEMENTS);

   state_type                state_ff, state_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     ready_ff, ready_in;
   logic                     trunc_ff, trunc_in;
   logic                     last_ff, last_in;
   logic [VALUE_WIDTH-1:0]   val_ff, val_in;
   logic [CW-1:0]            idx_ff, idx_in;
   logic [CW-1:0]            hi_ff, hi_in;
   logic [AW-1:0]            mid_ff, mid_in;
   logic [PW-1:0]            run_ff, run_in;
   logic [BudgetWidth-1:0]   budget_ff, budget_in;
   status_type               st_ff, st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]            rsp_fit_count_ff, rsp_fit_count_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   logic                     elem_we;
   logic [AW-1:0]            elem_waddr, elem_raddr;
   logic [VALUE_WIDTH-1:0]   elem_wdata, elem_rdata;
   logic                     pfx_we;
   logic [AW-1:0]            pfx_waddr, pfx_raddr;
   logic [PW-1:0]            pfx_wdata, pfx_rdata;

   logic                     accept;
   logic [CW-1:0]            base_cnt;
   logic [CW-1:0]            mid_full;
   logic [PW-1:0]            sum;

   psbc_ram #(.Width(VALUE_WIDTH), .Depth(MAX_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata)
   );

   psbc_ram #(.Width(PW), .Depth(MAX_ELEMENTS)) u_pfx_ram (
      .clock   (clock),
      .wr_en   (pfx_we),
      .wr_addr (pfx_waddr),
      .wr_data (pfx_wdata),
      .rd_addr (pfx_raddr),
      .rd_data (pfx_rdata)
   );

   assign req_stall     = (state_ff != S_IDLE);
   assign accept        = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fit_count = rsp_fit_count_ff;
   assign rsp_status    = rsp_status_ff;

   assign base_cnt = ready_ff ? '0 : cnt_ff;
   assign mid_full = idx_ff + ((hi_ff - idx_ff) >> 1);
   assign sum      = run_ff + PW'(elem_rdata);

   // sequence loads, sorting insertion, prefix pass and search
   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      ready_in         = ready_ff;
      trunc_in         = trunc_ff;
      last_in          = last_ff;
      val_in           = val_ff;
      idx_in           = idx_ff;
      hi_in            = hi_ff;
      mid_in           = mid_ff;
      run_in           = run_ff;
      budget_in        = budget_ff;
      st_in            = st_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_fit_count_in = rsp_fit_count_ff;
      rsp_status_in    = rsp_status_ff;
      elem_we          = 1'b0;
      elem_waddr       = idx_ff[AW-1:0];
      elem_wdata       = val_ff;
      elem_raddr       = idx_ff[AW-1:0];
      pfx_we           = 1'b0;
      pfx_waddr        = idx_ff[AW-1:0];
      pfx_wdata        = sum;
      pfx_raddr        = mid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_command) begin
                  // drop a held set before loading the new one
                  ready_in = 1'b0;
                  trunc_in = ready_ff ? 1'b0 : trunc_ff;
                  last_in  = req_last_element;
                  idx_in   = '0;
                  run_in   = '0;
                  if (base_cnt == MaxCount) begin
                     trunc_in = 1'b1;
                     cnt_in   = base_cnt;
                     state_in = req_last_element ? S_PFX_RD : S_IDLE;
                  end else begin
                     val_in   = VALUE_WIDTH'(req_element_value);
                     idx_in   = base_cnt;
                     cnt_in   = base_cnt + 1'b1;
                     state_in = S_INS_RD;
                  end
               end else begin
                  idx_in    = '0;
                  hi_in     = cnt_ff;
                  budget_in = req_query_sum;
                  if (!ready_ff) begin
                     st_in    = ST_NOT_READY;
                     state_in = S_RESP;
                  end else begin
                     st_in    = trunc_ff ? ST_TRUNCATED : ST_OK;
                     state_in = S_Q_RD;
                  end
               end
            end
         end
         S_INS_RD: begin
            // place the value at the bottom or fetch the entry below
            if (idx_ff == '0) begin
               elem_we    = 1'b1;
               elem_waddr = '0;
               elem_wdata = val_ff;
               idx_in     = '0;
               run_in     = '0;
               state_in   = last_ff ? S_PFX_RD : S_IDLE;
            end else begin
               elem_raddr = AW'(idx_ff - 1'b1);
               state_in   = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            elem_we    = 1'b1;
            elem_waddr = idx_ff[AW-1:0];
            if (elem_rdata > val_ff) begin
               // shift the larger entry up one place
               elem_wdata = elem_rdata;
               idx_in     = idx_ff - 1'b1;
               state_in   = S_INS_RD;
            end else begin
               elem_wdata = val_ff;
               idx_in     = '0;
               run_in     = '0;
               state_in   = last_ff ? S_PFX_RD : S_IDLE;
            end
         end
         S_PFX_RD: begin
            elem_raddr = idx_ff[AW-1:0];
            state_in   = S_PFX_ACC;
         end
         S_PFX_ACC: begin
            // accumulate and store one running sum
            pfx_we    = 1'b1;
            pfx_waddr = idx_ff[AW-1:0];
            pfx_wdata = sum;
            run_in    = sum;
            if (idx_ff + 1'b1 == cnt_ff) begin
               ready_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_PFX_RD;
            end
         end
         S_Q_RD: begin
            if (idx_ff < hi_ff) begin
               pfx_raddr = mid_full[AW-1:0];
               mid_in    = mid_full[AW-1:0];
               state_in  = S_Q_CMP;
            end else begin
               state_in = S_RESP;
            end
         end
         S_Q_CMP: begin
            // narrow the search window
            if (CPW'(pfx_rdata) <= CPW'(budget_ff)) begin
               idx_in = CW'(mid_ff) + 1'b1;
            end else begin
               hi_in = CW'(mid_ff);
            end
            state_in = S_Q_RD;
         end
         S_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_fit_count_in = idx_ff;
               rsp_status_in    = st_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ready_ff     <= 1'b0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ready_ff     <= ready_in;
         trunc_ff     <= trunc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      last_ff          <= last_in;
      val_ff           <= val_in;
      idx_ff           <= idx_in;
      hi_ff            <= hi_in;
      mid_ff           <= mid_in;
      run_ff           <= run_in;
      budget_ff        <= budget_in;
      st_ff            <= st_in;
      rsp_fit_count_ff <= rsp_fit_count_in;
      rsp_status_ff    <= rsp_status_in;
   end

endmodule
`default_nettype wire
